// ----- design/smm_pkg.sv -----
package smm_pkg;

   localparam int ELEM_W          = 64;
   localparam int HALF_W          = ELEM_W / 2;
   localparam int CSR_W           = 4;
   localparam int LIN_W           = 2 * CSR_W;
   localparam int MAX_DIM_DEFAULT = 8;

   localparam logic [CSR_W-1:0] MATRIX_SIZE_RESET = 4'd8;

   localparam logic FUNC_LOAD_A = 1'b0;
   localparam logic FUNC_LOAD_B = 1'b1;

   // partial product selection for the shared 32x32 multiplier
   typedef enum logic [1:0] {
      MUL_LO_LO = 2'd0,
      MUL_LO_HI = 2'd1,
      MUL_HI_LO = 2'd2
   } mul_sel_type;

   typedef struct packed {
      logic        clear;
      logic        add_en;
      mul_sel_type sel;
   } mac_ctrl_type;

endpackage

// ----- design/smm_channels.sv -----
interface smm_req_if;
   logic                              valid;
   logic                              ready;
   logic                              func;
   logic signed [smm_pkg::ELEM_W-1:0] element;

   modport source (output valid, func, element, input ready);
   modport sink   (input valid, func, element, output ready);
endinterface

interface smm_rsp_if;
   logic                              valid;
   logic                              ready;
   logic signed [smm_pkg::ELEM_W-1:0] product_entry;
   logic                              last;

   modport source (output valid, product_entry, last, input ready);
   modport sink   (input valid, product_entry, last, output ready);
endinterface

// ----- design/smm_store.sv -----
module smm_store #(
   parameter int DEPTH  = smm_pkg::MAX_DIM_DEFAULT * smm_pkg::MAX_DIM_DEFAULT,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                       clock,
   input  logic                       a_we,
   input  logic [ADDR_W-1:0]          a_waddr,
   input  logic                       b_we,
   input  logic [ADDR_W-1:0]          b_waddr,
   input  logic [smm_pkg::ELEM_W-1:0] wdata,
   input  logic [ADDR_W-1:0]          a_raddr,
   input  logic [ADDR_W-1:0]          b_raddr,
   output logic [smm_pkg::ELEM_W-1:0] a_rdata,
   output logic [smm_pkg::ELEM_W-1:0] b_rdata
);

   logic [smm_pkg::ELEM_W-1:0] a_mem [DEPTH];
   logic [smm_pkg::ELEM_W-1:0] b_mem [DEPTH];
   logic [smm_pkg::ELEM_W-1:0] a_rd_ff;
   logic [smm_pkg::ELEM_W-1:0] b_rd_ff;

   // one write and one registered read per store per cycle
   always_ff @(posedge clock) begin
      if (a_we) begin
         a_mem[a_waddr] <= wdata;
      end
      a_rd_ff <= a_mem[a_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         b_mem[b_waddr] <= wdata;
      end
      b_rd_ff <= b_mem[b_raddr];
   end

   assign a_rdata = a_rd_ff;
   assign b_rdata = b_rd_ff;

endmodule

// ----- design/smm_mac.sv -----
module smm_mac (
   input  logic                       clock,
   input  smm_pkg::mac_ctrl_type      ctrl,
   input  logic [smm_pkg::ELEM_W-1:0] a_op,
   input  logic [smm_pkg::ELEM_W-1:0] b_op,
   output logic [smm_pkg::ELEM_W-1:0] acc
);

   localparam int HW = smm_pkg::HALF_W;
   localparam int EW = smm_pkg::ELEM_W;

   logic [HW-1:0] mul_x;
   logic [HW-1:0] mul_y;
   logic [EW-1:0] mul_in;
   logic [EW-1:0] mul_ff;
   logic          shift_in;
   logic          shift_ff;
   logic [EW-1:0] addend;
   logic [EW-1:0] acc_in;
   logic [EW-1:0] acc_ff;

   // low 64 bits of a*b: lo*lo plus both cross terms moved up by half a word
   always_comb begin
      case (ctrl.sel)
         smm_pkg::MUL_LO_LO: begin
            mul_x = a_op[HW-1:0];
            mul_y = b_op[HW-1:0];
         end
         smm_pkg::MUL_LO_HI: begin
            mul_x = a_op[HW-1:0];
            mul_y = b_op[EW-1:HW];
         end
         smm_pkg::MUL_HI_LO: begin
            mul_x = a_op[EW-1:HW];
            mul_y = b_op[HW-1:0];
         end
         default: begin
            mul_x = '0;
            mul_y = '0;
         end
      endcase
   end

   assign mul_in   = EW'(mul_x) * EW'(mul_y);
   assign shift_in = (ctrl.sel != smm_pkg::MUL_LO_LO);

   always_ff @(posedge clock) begin
      mul_ff   <= mul_in;
      shift_ff <= shift_in;
   end

   assign addend = shift_ff ? {mul_ff[HW-1:0], {HW{1'b0}}} : mul_ff;

   always_comb begin
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (ctrl.add_en) begin
         acc_in = acc_ff + addend;
      end else begin
         acc_in = acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

// ----- design/square_matrix_multiply_top.sv -----
// Channel     | Port        | Direction | Payload
// ------------+-------------+-----------+----------------------------------------
// request     | req_if      | in        | func (0 = load A, 1 = load B), element
// response    | rsp_if      | out       | product_entry, last
// control reg | csr_wr_*    | in        | matrix_size (4 bits), write only
//
// Load transactions are taken while idle; the block stays ready between them.
// The transaction that completes B starts a run: each of the n terms of an entry
// takes a store read (FETCH) and three passes through one 32x32 multiplier (PP0 to
// PP2), ACC adds the last product, and FLUSH hands the entry to the output register.
// The request side is not ready during a run; a stalled response holds the run.
// Reset is synchronous: fill counts clear and matrix_size returns to 8.

module square_matrix_multiply_top #(
   parameter int MAX_DIM = smm_pkg::MAX_DIM_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   smm_req_if.sink                   req_if,
   smm_rsp_if.source                 rsp_if,
   input  logic                      csr_wr_en,
   input  logic [smm_pkg::CSR_W-1:0] csr_wr_data
);

   localparam int DEPTH  = MAX_DIM * MAX_DIM;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FILL_W = $clog2(DEPTH + 1);
   localparam int CNT_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CSR_W  = smm_pkg::CSR_W;
   localparam int LIN_W  = smm_pkg::LIN_W;
   localparam int EW     = smm_pkg::ELEM_W;

   typedef enum logic [6:0] {
      ST_IDLE  = 7'b0000001,
      ST_FETCH = 7'b0000010,
      ST_PP0   = 7'b0000100,
      ST_PP1   = 7'b0001000,
      ST_PP2   = 7'b0010000,
      ST_ACC   = 7'b0100000,
      ST_FLUSH = 7'b1000000
   } state_type;

   state_type             state_ff, state_in;
   logic [CSR_W-1:0]      size_ff, size_in;
   logic [FILL_W-1:0]     a_fill_ff, a_fill_in;
   logic [FILL_W-1:0]     b_fill_ff, b_fill_in;
   logic [CNT_W-1:0]      i_ff, i_in;
   logic [CNT_W-1:0]      j_ff, j_in;
   logic [CNT_W-1:0]      k_ff, k_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [EW-1:0]         rsp_data_ff;
   logic                  rsp_last_ff;

   logic [CSR_W-1:0]      dim;
   logic [CSR_W-1:0]      dim_m1;
   logic [LIN_W-1:0]      total;
   logic                  req_accept;
   logic                  a_room;
   logic                  b_room;
   logic                  a_we;
   logic                  b_we;
   logic                  run_start;
   logic                  k_last;
   logic                  j_last;
   logic                  i_last;
   logic                  out_load;
   logic [LIN_W-1:0]      a_lin;
   logic [LIN_W-1:0]      b_lin;
   logic [EW-1:0]         a_rdata;
   logic [EW-1:0]         b_rdata;
   logic [EW-1:0]         acc;
   smm_pkg::mac_ctrl_type mac_ctrl;

   // Dimension in use: zero acts as one, anything above the maximum as the maximum.
   always_comb begin
      if (size_ff == '0) begin
         dim = CSR_W'(1);
      end else if (size_ff > CSR_W'(MAX_DIM)) begin
         dim = CSR_W'(MAX_DIM);
      end else begin
         dim = size_ff;
      end
   end

   assign dim_m1 = dim - CSR_W'(1);
   assign total  = LIN_W'(dim) * LIN_W'(dim);

   // Request side: loads are taken only between runs.
   assign req_if.ready = (state_ff == ST_IDLE);
   assign req_accept   = req_if.valid && req_if.ready;

   assign a_room    = LIN_W'(a_fill_ff) < total;
   assign b_room    = LIN_W'(b_fill_ff) < total;
   assign a_we      = req_accept && (req_if.func == smm_pkg::FUNC_LOAD_A) && a_room;
   assign b_we      = req_accept && (req_if.func == smm_pkg::FUNC_LOAD_B) && b_room;
   // B is complete once the count, including this transaction, reaches n*n
   assign run_start = req_accept && (req_if.func == smm_pkg::FUNC_LOAD_B)
                      && ((LIN_W'(b_fill_ff) + LIN_W'(b_room)) >= total);

   assign k_last = (CSR_W'(k_ff) == dim_m1);
   assign j_last = (CSR_W'(j_ff) == dim_m1);
   assign i_last = (CSR_W'(i_ff) == dim_m1);

   // Hand the finished entry over when the output register is free or being drained.
   assign out_load = (state_ff == ST_FLUSH) && (!rsp_valid_ff || rsp_if.ready);

   // Row-major addresses: A[i][k] and B[k][j].
   assign a_lin = LIN_W'(i_ff) * LIN_W'(dim) + LIN_W'(k_ff);
   assign b_lin = LIN_W'(k_ff) * LIN_W'(dim) + LIN_W'(j_ff);

   // Sequencer
   always_comb begin
      state_in  = state_ff;
      size_in   = size_ff;
      a_fill_in = a_fill_ff;
      b_fill_in = b_fill_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      k_in      = k_ff;

      mac_ctrl.clear  = 1'b0;
      mac_ctrl.add_en = 1'b0;
      mac_ctrl.sel    = smm_pkg::MUL_LO_LO;

      case (state_ff)
         ST_IDLE: begin
            if (a_we) begin
               a_fill_in = a_fill_ff + FILL_W'(1);
            end
            if (b_we) begin
               b_fill_in = b_fill_ff + FILL_W'(1);
            end
            if (run_start) begin
               a_fill_in      = '0;
               b_fill_in      = '0;
               i_in           = '0;
               j_in           = '0;
               k_in           = '0;
               mac_ctrl.clear = 1'b1;
               state_in       = ST_FETCH;
            end
         end
         ST_FETCH: begin
            state_in = ST_PP0;
         end
         ST_PP0: begin
            mac_ctrl.sel = smm_pkg::MUL_LO_LO;
            state_in     = ST_PP1;
         end
         ST_PP1: begin
            mac_ctrl.sel    = smm_pkg::MUL_LO_HI;
            mac_ctrl.add_en = 1'b1;
            state_in        = ST_PP2;
         end
         ST_PP2: begin
            mac_ctrl.sel    = smm_pkg::MUL_HI_LO;
            mac_ctrl.add_en = 1'b1;
            state_in        = ST_ACC;
         end
         ST_ACC: begin
            mac_ctrl.add_en = 1'b1;
            if (k_last) begin
               state_in = ST_FLUSH;
            end else begin
               k_in     = k_ff + CNT_W'(1);
               state_in = ST_FETCH;
            end
         end
         ST_FLUSH: begin
            if (out_load) begin
               mac_ctrl.clear = 1'b1;
               k_in           = '0;
               if (j_last) begin
                  j_in = '0;
                  if (i_last) begin
                     state_in = ST_IDLE;
                  end else begin
                     i_in     = i_ff + CNT_W'(1);
                     state_in = ST_FETCH;
                  end
               end else begin
                  j_in     = j_ff + CNT_W'(1);
                  state_in = ST_FETCH;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a size write abandons any partial load; the user must write it only while idle, the block does not enforce this
      if (csr_wr_en) begin
         size_in   = csr_wr_data;
         a_fill_in = '0;
         b_fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         size_ff   <= smm_pkg::MATRIX_SIZE_RESET;
         a_fill_ff <= '0;
         b_fill_ff <= '0;
         i_ff      <= '0;
         j_ff      <= '0;
         k_ff      <= '0;
      end else begin
         state_ff  <= state_in;
         size_ff   <= size_in;
         a_fill_ff <= a_fill_in;
         b_fill_ff <= b_fill_in;
         i_ff      <= i_in;
         j_ff      <= j_in;
         k_ff      <= k_in;
      end
   end

   // Output register: parts the run from a stalled response side.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_data_ff <= acc;
         rsp_last_ff <= i_last && j_last;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.product_entry = rsp_data_ff;
   assign rsp_if.last          = rsp_last_ff;

   smm_store #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_store (
      .clock   (clock),
      .a_we    (a_we),
      .a_waddr (a_fill_ff[ADDR_W-1:0]),
      .b_we    (b_we),
      .b_waddr (b_fill_ff[ADDR_W-1:0]),
      .wdata   (req_if.element),
      .a_raddr (a_lin[ADDR_W-1:0]),
      .b_raddr (b_lin[ADDR_W-1:0]),
      .a_rdata (a_rdata),
      .b_rdata (b_rdata)
   );

   smm_mac u_mac (
      .clock (clock),
      .ctrl  (mac_ctrl),
      .a_op  (a_rdata),
      .b_op  (b_rdata),
      .acc   (acc)
   );

   // A response only appears from the hand-over state.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FLUSH))
      else $error("response raised outside hand-over");

   // Fill counts never run past n*n.
   assert property (@(posedge clock) disable iff (reset)
      (LIN_W'(a_fill_ff) <= total) && (LIN_W'(b_fill_ff) <= total))
      else $error("fill count beyond matrix size");

   // A size write abandons any partial load.
   assert property (@(posedge clock) disable iff (reset)
      csr_wr_en |=> (a_fill_ff == '0) && (b_fill_ff == '0))
      else $error("fill counts survive a size write");

   // Handing over the final entry ends the run.
   assert property (@(posedge clock) disable iff (reset)
      (out_load && i_last && j_last) |=> (state_ff == ST_IDLE) && rsp_last_ff)
      else $error("run did not end on its final entry");

   // Request side is closed once a run starts.
   assert property (@(posedge clock) disable iff (reset)
      run_start |=> !req_if.ready)
      else $error("request accepted during a run");

endmodule
